[design/bubble_sort_with_counts_macros.svh]
// ----------------------------------------------------------------------------
// bubble_sort_with_counts_macros.svh
// Assertion macros shared by the sorter RTL. Each expects clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef BUBBLE_SORT_WITH_COUNTS_MACROS_SVH
`define BUBBLE_SORT_WITH_COUNTS_MACROS_SVH

// same-cycle implication, disabled in reset
`define BSC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/bsc_pkg.sv]
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and sizes for the bubble sorter with swap/compare counts.
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam int MAX_KEYS = 64;
	localparam int KEY_W    = 32;
	localparam int TOT_W    = 11;
	localparam int ADDR_W   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);

	// input beat
	typedef struct packed {
		logic [KEY_W-1:0] item_value;
		logic             item_last;
	} item_t;

	// output beat
	typedef struct packed {
		logic [KEY_W-1:0] sorted_value;
		logic [TOT_W-1:0] swap_total;
		logic [TOT_W-1:0] compare_total;
		logic             overflow_flag;
		logic             result_last;
	} result_t;

	// controls from the sequencer to the compare/swap unit
	typedef struct packed {
		logic clr;   // clear swap and compare totals
		logic load;  // start of pass: take first key into hold, clear moved
		logic step;  // one compare of hold against the key just read
	} cmp_ctl_t;

endpackage

[design/bsc_key_ram.sv]
// ----------------------------------------------------------------------------
// bsc_key_ram
// Key store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsc_key_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [bsc_pkg::ADDR_W-1:0] waddr,
	input  logic [bsc_pkg::KEY_W-1:0]  wdata,
	input  logic                      re,
	input  logic [bsc_pkg::ADDR_W-1:0] raddr,
	output logic [bsc_pkg::KEY_W-1:0]  rdata
);
	import bsc_pkg::*;

	logic [KEY_W-1:0] mem [MAX_KEYS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data valid the cycle after re
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/bsc_cmp_unit.sv]
// ----------------------------------------------------------------------------
// bsc_cmp_unit
// Shared compare/swap unit. Holds the key that bubbles up through a pass,
// compares it against each key read from the store and keeps the totals.
// ----------------------------------------------------------------------------
`include "bubble_sort_with_counts_macros.svh"

module bsc_cmp_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bsc_pkg::cmp_ctl_t        ctl,
	input  logic [bsc_pkg::KEY_W-1:0] rd_data,
	output logic [bsc_pkg::KEY_W-1:0] wr_data,
	output logic [bsc_pkg::KEY_W-1:0] hold,
	output logic                     moved,
	output logic [bsc_pkg::TOT_W-1:0] swap_total,
	output logic [bsc_pkg::TOT_W-1:0] compare_total
);
	import bsc_pkg::*;

	logic [KEY_W-1:0] hold_q;
	logic             moved_q;
	logic [TOT_W-1:0] swap_q;
	logic [TOT_W-1:0] cmp_q;
	logic             gt;

	// strict greater-than: equal keys stay put
	assign gt      = hold_q > rd_data;
	// the smaller of the pair drops to the lower slot
	assign wr_data = gt ? rd_data : hold_q;

	// bubbling key: larger one travels on
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hold_q <= rd_data;
		end else if (ctl.step && !gt) begin
			hold_q <= rd_data;
		end
	end

	// swap flag of the current pass and run totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moved_q <= 1'b0;
			swap_q  <= '0;
			cmp_q   <= '0;
		end else begin
			if (ctl.load) begin
				moved_q <= 1'b0;
			end else if (ctl.step && gt) begin
				moved_q <= 1'b1;
			end
			if (ctl.clr) begin
				swap_q <= '0;
				cmp_q  <= '0;
			end else if (ctl.step) begin
				cmp_q <= cmp_q + TOT_W'(1);
				if (gt) begin
					swap_q <= swap_q + TOT_W'(1);
				end
			end
		end
	end

	assign hold          = hold_q;
	assign moved         = moved_q;
	assign swap_total    = swap_q;
	assign compare_total = cmp_q;

	`BSC_ASSERT_NEXT(a_swap_sets_moved, ctl.step && gt && !ctl.load, moved_q, "swap did not set moved flag")
	`BSC_ASSERT_NEXT(a_load_clears_moved, ctl.load, !moved_q, "pass start did not clear moved flag")
	`BSC_ASSERT_IMPL(a_swaps_le_compares, 1'b1, swap_q <= cmp_q, "more swaps than compares")

endmodule

[design/bubble_sort_with_counts.sv]
// Sequence: keys are taken in the load state; after the last key a start state, then each pass
// of L compares runs pass start, one compare per cycle (through the shared unit and the key
// store's single read and write ports) and pass end; each result is held until taken.
// Throughput: one set at a time; no input is taken from the last key until its final result.
// Reset: asynchronous, clears count, overflow flag and sequencer; the store is not cleared.
// ----------------------------------------------------------------------------
// bubble_sort_with_counts
// Collects up to MAX_KEYS keys, bubble sorts them with early exit and streams
// them out ascending with the run's swap and compare totals.
// ----------------------------------------------------------------------------
`include "bubble_sort_with_counts_macros.svh"

module bubble_sort_with_counts (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bsc_pkg::item_t   in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output bsc_pkg::result_t out_data
);
	import bsc_pkg::*;

	// sequencer states
	localparam logic [2:0] ST_LOAD  = 3'd0;  // taking keys
	localparam logic [2:0] ST_RD0   = 3'd1;  // read key 0, clear totals
	localparam logic [2:0] ST_LD0   = 3'd2;  // pass start: hold key 0, read key 1
	localparam logic [2:0] ST_CMP   = 3'd3;  // one compare per cycle
	localparam logic [2:0] ST_PEND  = 3'd4;  // pass end: write hold, read key 0
	localparam logic [2:0] ST_ELD   = 3'd5;  // capture result into output register
	localparam logic [2:0] ST_EWAIT = 3'd6;  // result beat offered

	logic [2:0]        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              drop_q;
	logic [ADDR_W-1:0] lim_q;
	logic [ADDR_W-1:0] k_q;
	logic [ADDR_W-1:0] e_q;
	result_t           out_q;

	logic              in_acc, out_acc;
	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [KEY_W-1:0]  wdata, rdata;
	cmp_ctl_t          ctl;
	logic [KEY_W-1:0]  cu_wr_data, cu_hold;
	logic              cu_moved;
	logic [TOT_W-1:0]  cu_swaps, cu_cmps;
	logic [ADDR_W-1:0] k_inc;
	logic [CNT_W-1:0]  cnt_m1;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_EWAIT);
	assign out_data  = out_q;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign k_inc     = k_q + ADDR_W'(1);
	assign cnt_m1    = cnt_q - CNT_W'(1);

	bsc_key_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	bsc_cmp_unit u_cmp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.rd_data       (rdata),
		.wr_data       (cu_wr_data),
		.hold          (cu_hold),
		.moved         (cu_moved),
		.swap_total    (cu_swaps),
		.compare_total (cu_cmps)
	);

	// store ports, unit controls and next state
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = cu_wr_data;
		re      = 1'b0;
		raddr   = '0;
		ctl     = '0;
		case (state_q)
			ST_LOAD: begin
				if (in_acc) begin
					if (cnt_q < CNT_W'(MAX_KEYS)) begin
						we    = 1'b1;
						waddr = cnt_q[ADDR_W-1:0];
						wdata = in_data.item_value;
					end
					if (in_data.item_last) begin
						state_d = ST_RD0;
					end
				end
			end
			ST_RD0: begin
				re      = 1'b1;
				ctl.clr = 1'b1;
				state_d = (cnt_q >= CNT_W'(2)) ? ST_LD0 : ST_ELD;
			end
			ST_LD0: begin
				ctl.load = 1'b1;
				re       = 1'b1;
				raddr    = ADDR_W'(1);
				state_d  = ST_CMP;
			end
			ST_CMP: begin
				ctl.step = 1'b1;
				we       = 1'b1;
				waddr    = k_q;
				re       = 1'b1;
				raddr    = k_q + ADDR_W'(2);
				if (k_inc == lim_q) begin
					state_d = ST_PEND;
				end
			end
			ST_PEND: begin
				we      = 1'b1;
				waddr   = lim_q;
				wdata   = cu_hold;
				re      = 1'b1;
				state_d = (cu_moved && lim_q != ADDR_W'(1)) ? ST_LD0 : ST_ELD;
			end
			ST_ELD: begin
				state_d = ST_EWAIT;
			end
			ST_EWAIT: begin
				if (out_acc) begin
					if (out_q.result_last) begin
						state_d = ST_LOAD;
					end else begin
						re      = 1'b1;
						raddr   = e_q + ADDR_W'(1);
						state_d = ST_ELD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// sequencer, key count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			lim_q   <= '0;
			k_q     <= '0;
			e_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (cnt_q < CNT_W'(MAX_KEYS)) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				ST_RD0: begin
					lim_q <= cnt_m1[ADDR_W-1:0];
					e_q   <= '0;
				end
				ST_LD0: begin
					k_q <= '0;
				end
				ST_CMP: begin
					k_q <= k_inc;
				end
				ST_PEND: begin
					lim_q <= lim_q - ADDR_W'(1);
					e_q   <= '0;
				end
				ST_EWAIT: begin
					if (out_acc) begin
						if (out_q.result_last) begin
							cnt_q  <= '0;
							drop_q <= 1'b0;
						end else begin
							e_q <= e_q + ADDR_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register, loaded from the store's read data, run totals, overflow flag and last marker
	always_ff @(posedge clk) begin
		if (state_q == ST_ELD) begin
			out_q.sorted_value  <= rdata;
			out_q.swap_total    <= cu_swaps;
			out_q.compare_total <= cu_cmps;
			out_q.overflow_flag <= drop_q;
			out_q.result_last   <= (CNT_W'(e_q) == cnt_m1);
		end
	end

	`BSC_ASSERT_IMPL(a_one_side_only, in_ready, !out_valid, "input and output open together")
	`BSC_ASSERT_IMPL(a_count_in_range, 1'b1, cnt_q <= CNT_W'(MAX_KEYS), "key count beyond store")
	`BSC_ASSERT_IMPL(a_cmp_in_pass, state_q == ST_CMP, k_q < lim_q, "compare index past pass end")
	`BSC_ASSERT_NEXT(a_last_reopens, out_acc && out_data.result_last, in_ready && cnt_q == '0, "set not closed after last result")

endmodule
